@@ rtl/rhsv_pkg.sv @@
package rhsv_pkg;

	// Channel that holds the largest byte; it picks the hue sector.
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Number of register stages that the long divisions are spread over.
	localparam int DIV_STAGES = 4;
	// Quotient bits retired per divider stage for saturation and hue.
	localparam int SAT_STEPS = 4;
	localparam int HUE_STEPS = 3;
	// Total valid bits: front (2), divider stages, output register.
	localparam int NUM_STAGES = DIV_STAGES + 3;

	// Hue constants in 1/64 degree units.
	localparam logic signed [15:0] HUE_RED_BASE = 16'sd0;
	localparam logic signed [15:0] HUE_GREEN_BASE = 16'sd7680;
	localparam logic signed [15:0] HUE_BLUE_BASE = 16'sd15360;
	localparam logic signed [15:0] HUE_FULL_TURN = 16'sd23040;

	// Result of the max/min and sector decision.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] mx;
		logic [7:0] delta;
		sector_t    sector;
		logic       neg;
		logic [7:0] absdiff;
	} front_t;

	// Working state of both divisions as it moves down the pipeline.
	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  mx;
		logic [7:0]  delta;
		sector_t     sector;
		logic        neg;
		logic [7:0]  sat_rem;
		logic [15:0] sat_low;
		logic [15:0] sat_quo;
		logic [7:0]  hue_rem;
		logic [11:0] hue_low;
		logic [11:0] hue_quo;
	} div_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [8:0] div_step(logic [7:0] rem, logic din, logic [7:0] dvs);
		logic [8:0] trial;
		logic [8:0] diff;
		trial = {rem, din};
		diff = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			div_step = {1'b1, diff[7:0]};
		end else begin
			div_step = {1'b0, trial[7:0]};
		end
	endfunction

endpackage

@@ rtl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter for packed ARGB pixels.
// Pipeline: two front stages, four divider stages that share out both long
// divisions, and one output stage.
// Throughput: one pixel per cycle; each stage stalls only when it and all later ones are full.
// Reset clears the stage valid bits at once; data registers are not reset.
module rgb_to_hsv_converter
	import rhsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // packed_color[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // hue[14:0], saturation[30:15], brightness[38:31],
	                              // opacity[46:39], zero pad[47]
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	div_t                  pipe [0:DIV_STAGES];
	logic [14:0]           hue;
	logic [15:0]           saturation;
	logic [7:0]            brightness;
	logic [7:0]            opacity;

	// A stage may load when it is empty or the next stage loads too.
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	rhsv_front u_front (
		.clk      (clk),
		.en_s1    (en[0]),
		.en_s2    (en[1]),
		.pixel    (s_tdata),
		.front_s2 (pipe[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rhsv_div_stage u_div (
			.clk    (clk),
			.en     (en[k+2]),
			.div_in (pipe[k]),
			.div_sn (pipe[k+1])
		);
	end

	rhsv_back u_back (
		.clk        (clk),
		.en         (en[NUM_STAGES-1]),
		.div_in     (pipe[DIV_STAGES]),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.opacity    (opacity)
	);

	assign m_tdata = {1'b0, opacity, brightness, saturation, hue};

`ifndef SYNTHESIS
	// Input stalls only when every stage holds a pixel.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q))
		else $error("input stalled with an empty pipeline stage");

	// An accepted beat lands in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted beat lost at pipeline entry");

	// Hue stays within one full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] < 15'd23040))
		else $error("hue out of range");

	// Zero saturation means a grey pixel, whose hue is zero.
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[30:15] == 16'd0)) |-> (m_tdata[14:0] == 15'd0))
		else $error("grey pixel with nonzero hue");
`endif

endmodule

@@ rtl/rhsv_front.sv @@
module rhsv_front
	import rhsv_pkg::*;
(
	input  logic        clk,
	input  logic        en_s1,
	input  logic        en_s2,
	input  logic [31:0] pixel,
	output div_t        front_s2
);

	logic [7:0] red, green, blue;
	logic [8:0] diff;
	logic [7:0] mn;
	front_t     front_d;
	front_t     front_s1;
	logic [23:0] sat_dvd;
	logic [19:0] hue_dvd;

	assign red = pixel[23:16];
	assign green = pixel[15:8];
	assign blue = pixel[7:0];

	// Largest channel, ties resolved red first, then green, then blue.
	always_comb begin
		front_d.alpha = pixel[31:24];
		if (red >= green && red >= blue) begin
			front_d.sector = SEC_RED;
			front_d.mx = red;
			diff = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			front_d.sector = SEC_GREEN;
			front_d.mx = green;
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			front_d.sector = SEC_BLUE;
			front_d.mx = blue;
			diff = {1'b0, red} - {1'b0, green};
		end
		mn = (red <= green) ? red : green;
		if (blue < mn) begin
			mn = blue;
		end
		front_d.delta = front_d.mx - mn;
		front_d.neg = diff[8];
		front_d.absdiff = diff[8] ? 8'(-diff) : diff[7:0];
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			front_s1 <= front_d;
		end
	end

	// Dividends: delta * 65535 and |diff| * 3840, by shift and subtract.
	assign sat_dvd = {front_s1.delta, 16'h0000} - {16'h0000, front_s1.delta};
	assign hue_dvd = {front_s1.absdiff, 12'h000} - {4'h0, front_s1.absdiff, 8'h00};

	// The quotients fit 16 and 12 bits, so the top dividend byte seeds the remainder.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			front_s2.alpha <= front_s1.alpha;
			front_s2.mx <= front_s1.mx;
			front_s2.delta <= front_s1.delta;
			front_s2.sector <= front_s1.sector;
			front_s2.neg <= front_s1.neg;
			front_s2.sat_rem <= sat_dvd[23:16];
			front_s2.sat_low <= sat_dvd[15:0];
			front_s2.sat_quo <= '0;
			front_s2.hue_rem <= hue_dvd[19:12];
			front_s2.hue_low <= hue_dvd[11:0];
			front_s2.hue_quo <= '0;
		end
	end

endmodule

@@ rtl/rhsv_div_stage.sv @@
module rhsv_div_stage
	import rhsv_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t div_in,
	output div_t div_sn
);

	div_t       nxt;
	logic [8:0] sat_step;
	logic [8:0] hue_step;

	// Retire a few quotient bits of each division.
	always_comb begin
		nxt = div_in;
		sat_step = '0;
		hue_step = '0;
		for (int i = 0; i < SAT_STEPS; i++) begin
			sat_step = div_step(nxt.sat_rem, nxt.sat_low[15], nxt.mx);
			nxt.sat_rem = sat_step[7:0];
			nxt.sat_low = {nxt.sat_low[14:0], 1'b0};
			nxt.sat_quo = {nxt.sat_quo[14:0], sat_step[8]};
		end
		for (int i = 0; i < HUE_STEPS; i++) begin
			hue_step = div_step(nxt.hue_rem, nxt.hue_low[11], nxt.delta);
			nxt.hue_rem = hue_step[7:0];
			nxt.hue_low = {nxt.hue_low[10:0], 1'b0};
			nxt.hue_quo = {nxt.hue_quo[10:0], hue_step[8]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sn <= nxt;
		end
	end

endmodule

@@ rtl/rhsv_back.sv @@
module rhsv_back
	import rhsv_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  div_t        div_in,
	output logic [14:0] hue,
	output logic [15:0] saturation,
	output logic [7:0]  brightness,
	output logic [7:0]  opacity
);

	logic signed [15:0] base;
	logic signed [15:0] term;
	logic signed [15:0] hue_raw;
	logic signed [15:0] hue_wrap;

	// Sector offset plus the signed sector term, wrapped into one turn.
	always_comb begin
		unique case (div_in.sector)
			SEC_RED:   base = HUE_RED_BASE;
			SEC_GREEN: base = HUE_GREEN_BASE;
			SEC_BLUE:  base = HUE_BLUE_BASE;
			default:   base = HUE_RED_BASE;
		endcase
		term = $signed({4'h0, div_in.hue_quo});
		hue_raw = div_in.neg ? (base - term) : (base + term);
		hue_wrap = hue_raw[15] ? (hue_raw + HUE_FULL_TURN) : hue_raw;
	end

	// Grey and black pixels bypass the divisions, whose divisor is zero there.
	always_ff @(posedge clk) begin
		if (en) begin
			hue <= (div_in.delta == 8'd0) ? 15'd0 : hue_wrap[14:0];
			saturation <= (div_in.mx == 8'd0) ? 16'd0 : div_in.sat_quo;
			brightness <= div_in.mx;
			opacity <= div_in.alpha;
		end
	end

endmodule
